// ===== design/scta_pkg.sv =====
// scta_pkg: shared types, codes and key map tables for the scancode line-input block
// no dependencies; used by the interfaces, scta_decode and the top level
package scta_pkg;

  localparam int BUFFER_DEPTH_DEFAULT = 256;
  localparam int KEY_COUNT            = 128;
  localparam int KEY_AW               = 7;

  // function codes of an input item
  localparam logic [1:0] FUNC_SCAN  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // special table codes
  localparam logic [7:0] CODE_BACKSPACE = 8'h08;
  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] CODE_ESC       = 8'h1B;
  localparam logic [7:0] CODE_SHIFT     = 8'h3A;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] scancode;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       press_event;
    logic [7:0] char_code;
    logic       shift_active;
    logic [7:0] line_length;
    logic [7:0] stream_length;
    logic       dropped;
    logic [7:0] read_data;
  } out_item_t;

  // state update and memory write requests from the decode stage
  typedef struct packed {
    logic       shift_next;
    logic [7:0] line_next;
    logic [7:0] stream_next;
    logic       key_we;
    logic       key_wdata;
    logic       stream_we;
    logic [7:0] stream_wdata;
  } upd_t;

  function automatic logic [7:0] normal_map(input logic [KEY_AW-1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (idx)
      7'd1:  r = CODE_ESC;
      7'd2:  r = 8'h31;
      7'd3:  r = 8'h32;
      7'd4:  r = 8'h33;
      7'd5:  r = 8'h34;
      7'd6:  r = 8'h35;
      7'd7:  r = 8'h36;
      7'd8:  r = 8'h37;
      7'd9:  r = 8'h38;
      7'd10: r = 8'h39;
      7'd11: r = 8'h30;
      7'd12: r = 8'h2D;
      7'd13: r = 8'h3D;
      7'd14: r = CODE_BACKSPACE;
      7'd15: r = 8'h09;
      7'd16: r = 8'h71;
      7'd17: r = 8'h77;
      7'd18: r = 8'h65;
      7'd19: r = 8'h72;
      7'd20: r = 8'h74;
      7'd21: r = 8'h79;
      7'd22: r = 8'h75;
      7'd23: r = 8'h69;
      7'd24: r = 8'h6F;
      7'd25: r = 8'h70;
      7'd26: r = 8'h5B;
      7'd27: r = 8'h5D;
      7'd28: r = CODE_NEWLINE;
      7'd30: r = 8'h61;
      7'd31: r = 8'h73;
      7'd32: r = 8'h64;
      7'd33: r = 8'h66;
      7'd34: r = 8'h67;
      7'd35: r = 8'h68;
      7'd36: r = 8'h6A;
      7'd37: r = 8'h6B;
      7'd38: r = 8'h6C;
      7'd39: r = 8'h3B;
      7'd40: r = 8'h27;
      7'd41: r = 8'h60;
      7'd42: r = CODE_SHIFT;
      7'd43: r = 8'h5C;
      7'd44: r = 8'h7A;
      7'd45: r = 8'h78;
      7'd46: r = 8'h63;
      7'd47: r = 8'h76;
      7'd48: r = 8'h62;
      7'd49: r = 8'h6E;
      7'd50: r = 8'h6D;
      7'd51: r = 8'h2C;
      7'd52: r = 8'h2E;
      7'd53: r = 8'h2F;
      7'd54: r = 8'h3A;
      7'd55: r = 8'h2A;
      7'd57: r = 8'h20;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] shifted_map(input logic [KEY_AW-1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (idx)
      7'd1:  r = CODE_ESC;
      7'd2:  r = 8'h21;
      7'd3:  r = 8'h40;
      7'd4:  r = 8'h23;
      7'd5:  r = 8'h24;
      7'd6:  r = 8'h25;
      7'd7:  r = 8'h5E;
      7'd8:  r = 8'h26;
      7'd9:  r = 8'h2A;
      7'd10: r = 8'h28;
      7'd11: r = 8'h29;
      7'd12: r = 8'h5F;
      7'd13: r = 8'h2B;
      7'd14: r = CODE_BACKSPACE;
      7'd15: r = 8'h09;
      7'd16: r = 8'h51;
      7'd17: r = 8'h57;
      7'd18: r = 8'h45;
      7'd19: r = 8'h52;
      7'd20: r = 8'h54;
      7'd21: r = 8'h59;
      7'd22: r = 8'h55;
      7'd23: r = 8'h49;
      7'd24: r = 8'h4F;
      7'd25: r = 8'h50;
      7'd26: r = 8'h7B;
      7'd27: r = 8'h7D;
      7'd28: r = CODE_NEWLINE;
      7'd30: r = 8'h41;
      7'd31: r = 8'h53;
      7'd32: r = 8'h44;
      7'd33: r = 8'h46;
      7'd34: r = 8'h47;
      7'd35: r = 8'h48;
      7'd36: r = 8'h4A;
      7'd37: r = 8'h4B;
      7'd38: r = 8'h4C;
      7'd39: r = 8'h22;
      7'd40: r = 8'h3A;
      7'd41: r = 8'h7E;
      7'd42: r = CODE_SHIFT;
      7'd43: r = 8'h7C;
      7'd44: r = 8'h5A;
      7'd45: r = 8'h58;
      7'd46: r = 8'h43;
      7'd47: r = 8'h56;
      7'd48: r = 8'h42;
      7'd49: r = 8'h4E;
      7'd50: r = 8'h4D;
      7'd51: r = 8'h3C;
      7'd52: r = 8'h3E;
      7'd53: r = 8'h3F;
      7'd55: r = 8'h2A;
      7'd57: r = 8'h20;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== design/scta_if.sv =====
// scta_if: valid/ready channel interfaces for input and result items
// depends on scta_pkg for the payload types
interface scta_in_if;
  logic                 valid;
  logic                 ready;
  scta_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scta_out_if;
  logic                 valid;
  logic                 ready;
  scta_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/scta_ram.sv =====
// scta_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== design/scta_decode.sv =====
// scta_decode: second-stage decode of one item into its result and state updates
// depends on scta_pkg (types, codes, key map tables)
module scta_decode #(
  parameter int BUFFER_DEPTH = scta_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  scta_pkg::in_item_t  item,
  input  logic                held,
  input  logic [7:0]          stream_rd,
  input  logic                shift_on,
  input  logic [7:0]          line_count,
  input  logic [7:0]          stream_count,
  output scta_pkg::out_item_t res,
  output scta_pkg::upd_t      upd
);

  localparam logic [7:0] LIMIT = 8'((BUFFER_DEPTH - 1 < 255) ? BUFFER_DEPTH - 1 : 255);

  logic       is_release;
  logic [7:0] code;

  assign is_release = item.scancode[7];
  assign code = shift_on ? scta_pkg::shifted_map(item.scancode[6:0])
                         : scta_pkg::normal_map(item.scancode[6:0]);

  always_comb begin
    res = '0;
    upd.shift_next   = shift_on;
    upd.line_next    = line_count;
    upd.stream_next  = stream_count;
    upd.key_we       = 1'b0;
    upd.key_wdata    = 1'b0;
    upd.stream_we    = 1'b0;
    upd.stream_wdata = code;
    case (item.func)
      scta_pkg::FUNC_SCAN: begin
        // release clears the held bit, any press sets it
        upd.key_we    = 1'b1;
        upd.key_wdata = !is_release;
        if (!is_release && !held) begin
          res.press_event = 1'b1;
          res.char_code   = code;
          if (code == scta_pkg::CODE_SHIFT) begin
            upd.shift_next = !shift_on;
          end else if (code == scta_pkg::CODE_BACKSPACE) begin
            if (line_count != 8'd0) begin
              upd.line_next = line_count - 8'd1;
              if (stream_count != 8'd0) begin
                upd.stream_next = stream_count - 8'd1;
              end
            end
          end else if (code == scta_pkg::CODE_NEWLINE) begin
            if (stream_count < LIMIT) begin
              upd.stream_we   = 1'b1;
              upd.stream_next = stream_count + 8'd1;
            end else begin
              res.dropped = 1'b1;
            end
            upd.line_next = 8'd0;
          end else if (code != 8'd0) begin
            if (line_count < LIMIT) begin
              if (stream_count < LIMIT) begin
                upd.stream_we   = 1'b1;
                upd.stream_next = stream_count + 8'd1;
              end else begin
                res.dropped = 1'b1;
              end
              upd.line_next = line_count + 8'd1;
            end else begin
              res.dropped = 1'b1;
            end
          end
        end
      end
      scta_pkg::FUNC_CLEAR: begin
        upd.stream_next = 8'd0;
      end
      scta_pkg::FUNC_READ: begin
        if (item.read_index < stream_count) begin
          res.read_data = stream_rd;
        end
      end
      default: begin
      end
    endcase
    res.shift_active  = upd.shift_next;
    res.line_length   = upd.line_next;
    res.stream_length = upd.stream_next;
  end

endmodule

// ===== design/scancode_to_ascii_line_input.sv =====
// scancode_to_ascii_line_input: set-1 scancode decoder with a line-input character stream
// depends on scta_pkg, scta_if (channels), scta_ram and scta_decode
//
//   channel | direction | payload
//   --------+-----------+----------------------------------------------------------
//   req     | in        | func, scancode, read_index
//   rsp     | out       | press_event, char_code, shift_active, line_length,
//           |           | stream_length, dropped, read_data
//
// one item per cycle sustained while rsp is ready; an accepted item passes
// through the decode stage into the result register: the key-state and stream
// RAM reads are registered at the accepting edge, and decode and write-back
// happen as the item leaves the decode stage; reset starts a clearing pass over
// all 128 key-state RAM entries, during which req.ready stays low
// a stalled rsp holds its result register; the decode stage waits behind it
// and req.ready drops only when that stage cannot drain
module scancode_to_ascii_line_input #(
  parameter int BUFFER_DEPTH = scta_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  scta_in_if.sink          req,
  scta_out_if.source       rsp
);

  localparam int         SAW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [7:0] LIMIT = 8'((BUFFER_DEPTH - 1 < 255) ? BUFFER_DEPTH - 1 : 255);

  // key-state clearing pass
  logic                          clr_busy;
  logic [scta_pkg::KEY_AW-1:0]   clr_idx;

  // decode stage
  logic                          s2_valid;
  scta_pkg::in_item_t            s2_item;
  logic                          s2_adv;
  logic                          in_fire;

  // forwarding of a write that lands in the same cycle as the read
  logic                          fwd_key;
  logic                          fwd_key_val;
  logic                          fwd_st;
  logic [7:0]                    fwd_st_val;

  // architectural registers
  logic                          shift_on;
  logic [7:0]                    line_count;
  logic [7:0]                    stream_count;

  // result register
  logic                          out_valid;
  scta_pkg::out_item_t           out_data;

  // memory ports
  logic                          key_we;
  logic [scta_pkg::KEY_AW-1:0]   key_waddr;
  logic                          key_wdata;
  logic                          key_rdata;
  logic [SAW-1:0]                st_waddr;
  logic [SAW-1:0]                st_raddr;
  logic [7:0]                    st_rdata;

  logic                          held;
  logic [7:0]                    stream_rd;
  scta_pkg::out_item_t           res;
  scta_pkg::upd_t                upd;

  // decode drains when the result register is free or being emptied
  assign s2_adv    = s2_valid && (!out_valid || rsp.ready);
  assign req.ready = !clr_busy && (!s2_valid || s2_adv);
  assign in_fire   = req.valid && req.ready;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // key RAM writes come from the clearing pass or the decode stage
  assign key_we    = clr_busy || (s2_adv && upd.key_we);
  assign key_waddr = clr_busy ? clr_idx : s2_item.scancode[6:0];
  assign key_wdata = clr_busy ? 1'b0 : upd.key_wdata;

  // appends go to the slot at the current stream count
  assign st_waddr = SAW'(stream_count);
  assign st_raddr = SAW'(req.data.read_index);

  scta_ram #(
    .WIDTH (1),
    .DEPTH (scta_pkg::KEY_COUNT)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (in_fire),
    .raddr (req.data.scancode[6:0]),
    .rdata (key_rdata)
  );

  scta_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_stream_ram (
    .clk   (clk),
    .we    (s2_adv && upd.stream_we),
    .waddr (st_waddr),
    .wdata (upd.stream_wdata),
    .re    (in_fire),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign held      = fwd_key ? fwd_key_val : key_rdata;
  assign stream_rd = fwd_st ? fwd_st_val : st_rdata;

  scta_decode #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_decode (
    .item         (s2_item),
    .held         (held),
    .stream_rd    (stream_rd),
    .shift_on     (shift_on),
    .line_count   (line_count),
    .stream_count (stream_count),
    .res          (res),
    .upd          (upd)
  );

  // clearing pass over all key entries after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == scta_pkg::KEY_AW'(scta_pkg::KEY_COUNT - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // item capture and forwarding capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_fire) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_item     <= req.data;
      // the older item writes the same key while this one reads it
      fwd_key     <= s2_adv && upd.key_we
                     && (s2_item.scancode[6:0] == req.data.scancode[6:0]);
      fwd_key_val <= upd.key_wdata;
      // the older item appends to the slot this one reads
      fwd_st      <= s2_adv && upd.stream_we && (st_waddr == st_raddr);
      fwd_st_val  <= upd.stream_wdata;
    end
  end

  // architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_on     <= 1'b0;
      line_count   <= 8'd0;
      stream_count <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (s2_adv) begin
        shift_on     <= upd.shift_next;
        line_count   <= upd.line_next;
        stream_count <= upd.stream_next;
        out_valid    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data <= res;
    end
  end

  // no item taken while the key state is being cleared
  a_clr_blocks: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !req.ready)
    else $error("item accepted during key clearing pass");

  // counts never pass the limit
  a_limits: assert property (@(posedge clk) disable iff (rst)
    (stream_count <= LIMIT) && (line_count <= LIMIT))
    else $error("line or stream count beyond limit");

  // a stalled decode stage keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_adv |=> s2_valid && $stable(s2_item))
    else $error("decode stage lost its item while stalled");

  // a result without a press carries no code
  a_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.press_event |-> out_data.char_code == 8'd0)
    else $error("char code without press event");

endmodule

// ===== tb/sv/scancode_to_ascii_line_input_tb.sv =====
// scancode_to_ascii_line_input_tb: self-checking bench for the set-1 scancode line-input block
// drives req and checks rsp against a local model of key state, shift, line and stream
// depends on scta_pkg, scta_if and the block itself
module scancode_to_ascii_line_input_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scta_pkg::*;

  localparam int DEPTH      = BUFFER_DEPTH_DEFAULT;
  // line and stream both saturate at the smaller of depth-1 and 255
  localparam int LINE_LIMIT = (DEPTH - 1 < 255) ? DEPTH - 1 : 255;

  // function code 3 has no meaning in the block, it must leave state alone
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // set-1 scancodes used by the directed part
  localparam logic [7:0] SC_RELEASE   = 8'h80;
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_A         = 8'h1E;
  localparam logic [7:0] SC_B         = 8'h30;
  localparam logic [7:0] SC_QUOTE     = 8'h28;  // ':' when shifted, toggles shift
  localparam logic [7:0] SC_COLON     = 8'h36;  // ':' when not shifted, toggles shift
  localparam logic [7:0] SC_NONE      = 8'h00;  // unmapped
  localparam logic [7:0] SC_TOP       = 8'h7F;  // highest key, unmapped

  localparam int WATCHDOG_CYCLES = 2000;  // covers the clearing pass and long stalls
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_ITEMS     = 180;
  localparam int TAIL_ITEMS      = 100;
  localparam int LONG_LINE_TAPS  = 262;   // enough to pass both limits from an empty line

  // key maps, entry 0 in the top byte, keys above 57 are all unmapped
  localparam int KEYMAP_SIZE = 58;
  localparam logic [KEYMAP_SIZE*8-1:0] PLAIN_KEYS = {
    8'h00, CODE_ESC, "1234567890-=", CODE_BACKSPACE, "\tqwertyuiop[]", CODE_NEWLINE,
    8'h00, "asdfghjkl;'", 8'h60, CODE_SHIFT, "\\zxcvbnm,./:", "*", 8'h00, " "
  };
  localparam logic [KEYMAP_SIZE*8-1:0] SHIFTED_KEYS = {
    8'h00, CODE_ESC, "!@#$%^&*()_+", CODE_BACKSPACE, "\tQWERTYUIOP{}", CODE_NEWLINE,
    8'h00, "ASDFGHJKL\":~", CODE_SHIFT, "|ZXCVBNM<>?", 8'h00, "*", 8'h00, " "
  };

  typedef struct {
    in_item_t  stim;
    bit        typed;   // when set, want is the written-down result
    out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  scta_in_if  req ();
  scta_out_if rsp ();

  scancode_to_ascii_line_input uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // local copy of the block state
  logic       kbd_held [0:127];
  logic       shift_lock;
  int         line_chars;
  int         stream_chars;
  logic [7:0] stream_mem [0:DEPTH-1];

  out_item_t  pending_results [$];
  out_item_t  oldest;
  dir_row_t   dir_rows [$];
  logic [6:0] char_keys [$];

  int idle_pct;
  int stall_pct;
  int items_sent;
  int results_checked;
  int mismatches;
  int idle_cycles;
  int fresh_presses;
  int drops_seen;
  int stream_hits;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] key_code(logic shifted, logic [6:0] k);
    int pos;
    if (k >= KEYMAP_SIZE) return 8'h00;
    pos = (KEYMAP_SIZE - 1 - int'(k)) * 8;
    return shifted ? SHIFTED_KEYS[pos +: 8] : PLAIN_KEYS[pos +: 8];
  endfunction

  function automatic in_item_t item(logic [1:0] f, logic [7:0] sc, logic [7:0] idx);
    in_item_t it;
    it.func       = f;
    it.scancode   = sc;
    it.read_index = idx;
    return it;
  endfunction

  function automatic out_item_t result(logic p, logic [7:0] c, logic sh, logic [7:0] ln,
                                       logic [7:0] st, logic d, logic [7:0] rd);
    out_item_t r;
    r.press_event   = p;
    r.char_code     = c;
    r.shift_active  = sh;
    r.line_length   = ln;
    r.stream_length = st;
    r.dropped       = d;
    r.read_data     = rd;
    return r;
  endfunction

  // advances the local state by one item and returns the result it causes
  function automatic out_item_t decode_key_event(in_item_t it);
    out_item_t  r;
    logic [6:0] k;
    logic [7:0] c;
    r = '0;
    k = it.scancode[6:0];
    case (it.func)
      FUNC_SCAN: begin
        if (it.scancode[7]) begin
          kbd_held[k] = 1'b0;
        end else if (!kbd_held[k]) begin
          c             = key_code(shift_lock, k);
          r.press_event = 1'b1;
          r.char_code   = c;
          fresh_presses++;
          if (c == CODE_SHIFT) begin
            shift_lock = ~shift_lock;
          end else if (c == CODE_BACKSPACE) begin
            // only takes back what the current line typed
            if (line_chars > 0) begin
              line_chars--;
              if (stream_chars > 0) stream_chars--;
            end
          end else if (c == CODE_NEWLINE) begin
            // the line ends even when the newline cannot be stored
            if (stream_chars < LINE_LIMIT) begin
              stream_mem[stream_chars] = c;
              stream_chars++;
            end else begin
              r.dropped = 1'b1;
            end
            line_chars = 0;
          end else if (c != 8'h00) begin
            if (line_chars < LINE_LIMIT) begin
              // a full stream still lets the line grow
              if (stream_chars < LINE_LIMIT) begin
                stream_mem[stream_chars] = c;
                stream_chars++;
              end else begin
                r.dropped = 1'b1;
              end
              line_chars++;
            end else begin
              r.dropped = 1'b1;
            end
          end
          kbd_held[k] = 1'b1;
        end
      end
      FUNC_CLEAR: stream_chars = 0;  // line count survives a clear
      FUNC_READ: begin
        if (int'(it.read_index) < stream_chars && int'(it.read_index) < DEPTH) begin
          r.read_data = stream_mem[it.read_index];
          stream_hits++;
        end
      end
      default: ;
    endcase
    if (r.dropped) drops_seen++;
    r.shift_active  = shift_lock;
    r.line_length   = 8'(line_chars);
    r.stream_length = 8'(stream_chars);
    return r;
  endfunction

  // offers one item, waits for it to be taken and files what it should produce
  task automatic push_item(in_item_t it, bit use_typed = 1'b0, out_item_t typed = '0);
    out_item_t predicted;
    // random gap in front of the item
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= it;
    do @(posedge clk); while (!req.ready);
    predicted = decode_key_event(it);
    pending_results.push_back(use_typed ? typed : predicted);
    items_sent++;
  endtask

  // press and optionally let go of a key, releasing it first if still held
  task automatic tap_key(logic [6:0] k, bit let_go);
    if (kbd_held[k]) push_item(item(FUNC_SCAN, {1'b1, k}, rnd8()));
    push_item(item(FUNC_SCAN, {1'b0, k}, rnd8()));
    if (let_go) push_item(item(FUNC_SCAN, {1'b1, k}, rnd8()));
  endtask

  task automatic add_row(in_item_t s, bit typed, out_item_t w);
    dir_row_t row;
    row.stim  = s;
    row.typed = typed;
    row.want  = w;
    dir_rows.push_back(row);
  endtask

  // one random burst of typing, editing, reading or noise
  task automatic random_burst();
    int         pick;
    int         n;
    logic [6:0] k;
    logic [7:0] idx;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // a word, sometimes with shift flipped inside it, often ended by enter
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 5) k = 7'($urandom_range(127));
        else k = char_keys[$urandom_range(char_keys.size() - 1)];
        if ($urandom_range(99) < 10) tap_key(SC_LSHIFT[6:0], 1'b1);
        tap_key(k, $urandom_range(99) < 85);
      end
      if ($urandom_range(99) < 40) tap_key(SC_ENTER[6:0], 1'b1);
    end else if (pick < 55) begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) tap_key(SC_BACKSPACE[6:0], 1'b1);
    end else if (pick < 67) begin
      // reads mostly land inside the stream, some anywhere
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
        if (stream_chars > 0 && $urandom_range(99) < 75) idx = 8'($urandom_range(stream_chars - 1));
        else idx = rnd8();
        push_item(item(FUNC_READ, rnd8(), idx));
      end
    end else if (pick < 71) begin
      push_item(item(FUNC_CLEAR, rnd8(), rnd8()));
    end else if (pick < 79) begin
      if ($urandom_range(99) < 70) tap_key(SC_LSHIFT[6:0], 1'b1);
      else tap_key($urandom_range(1) ? SC_QUOTE[6:0] : SC_COLON[6:0], 1'b1);
    end else begin
      // raw noise over every field
      push_item(item(2'($urandom_range(3)), rnd8(), rnd8()));
    end
  endtask

  // one line long enough to hit the line limit and the stream limit
  task automatic long_line();
    tap_key(SC_ENTER[6:0], 1'b1);
    for (int i = 0; i < LONG_LINE_TAPS; i++)
      tap_key(char_keys[$urandom_range(char_keys.size() - 1)], 1'b1);
    // newline into a full stream, then typing into a full stream
    tap_key(SC_ENTER[6:0], 1'b1);
    for (int i = 0; i < 4; i++)
      tap_key(char_keys[$urandom_range(char_keys.size() - 1)], 1'b1);
    tap_key(SC_BACKSPACE[6:0], 1'b1);
    tap_key(SC_BACKSPACE[6:0], 1'b1);
    push_item(item(FUNC_READ, rnd8(), 8'(LINE_LIMIT - 2)));
    push_item(item(FUNC_READ, rnd8(), 8'hFF));
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver, stalls at the rate of the current phase
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("press_event",   8'(oldest.press_event),  8'(rsp.data.press_event));
        check_field("char_code",     oldest.char_code,        rsp.data.char_code);
        check_field("shift_active",  8'(oldest.shift_active), 8'(rsp.data.shift_active));
        check_field("line_length",   oldest.line_length,      rsp.data.line_length);
        check_field("stream_length", oldest.stream_length,    rsp.data.stream_length);
        check_field("dropped",       8'(oldest.dropped),      8'(rsp.data.dropped));
        check_field("read_data",     oldest.read_data,        rsp.data.read_data);
        results_checked++;
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_CYCLES);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int random_base;
    int phase_end;

    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.data  <= '0;
    idle_pct        = 0;
    stall_pct       = 0;
    items_sent      = 0;
    fresh_presses   = 0;
    drops_seen      = 0;
    stream_hits     = 0;
    shift_lock      = 1'b0;
    line_chars      = 0;
    stream_chars    = 0;
    for (int i = 0; i < 128; i++) kbd_held[i] = 1'b0;
    for (int i = 0; i < DEPTH; i++) stream_mem[i] = 8'h00;

    // keys that always append a character, whatever the shift state
    for (int i = 1; i < KEYMAP_SIZE; i++) begin
      if (!(key_code(1'b0, 7'(i)) inside {8'h00, CODE_SHIFT, CODE_BACKSPACE, CODE_NEWLINE}) &&
          !(key_code(1'b1, 7'(i)) inside {8'h00, CODE_SHIFT}))
        char_keys.push_back(7'(i));
    end

    // directed table
    // spare function code with every field at its top
    add_row(item(FUNC_SPARE, 8'hFF, 8'hFF), 1'b1, result(0, 8'h00, 0, 0, 0, 0, 8'h00));
    // read of an empty stream
    add_row(item(FUNC_READ, SC_NONE, 8'h00), 1'b1, result(0, 8'h00, 0, 0, 0, 0, 8'h00));
    // backspace on an empty line changes nothing
    add_row(item(FUNC_SCAN, SC_BACKSPACE, 8'h00), 1'b1,
            result(1, CODE_BACKSPACE, 0, 0, 0, 0, 8'h00));
    add_row(item(FUNC_SCAN, SC_BACKSPACE | SC_RELEASE, 8'h00), 1'b1,
            result(0, 8'h00, 0, 0, 0, 0, 8'h00));
    add_row(item(FUNC_SCAN, SC_A, 8'h00), 1'b1, result(1, 8'h61, 0, 1, 1, 0, 8'h00));
    // repeated press of a held key is ignored
    add_row(item(FUNC_SCAN, SC_A, 8'hFF), 1'b1, result(0, 8'h00, 0, 1, 1, 0, 8'h00));
    add_row(item(FUNC_SCAN, SC_A | SC_RELEASE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_LSHIFT, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_A, 8'h00), 1'b0, '0);
    // both colon positions flip shift as well
    add_row(item(FUNC_SCAN, SC_QUOTE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_COLON, 8'h00), 1'b0, '0);
    // unmapped presses, lowest and highest key
    add_row(item(FUNC_SCAN, SC_NONE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_TOP, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_TOP | SC_RELEASE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_READ, SC_NONE, 8'h00), 1'b0, '0);
    // read past the end
    add_row(item(FUNC_READ, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_ENTER, 8'h00), 1'b0, '0);
    // backspace with an empty line but a filled stream
    add_row(item(FUNC_SCAN, SC_BACKSPACE | SC_RELEASE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_BACKSPACE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_B, 8'h00), 1'b0, '0);
    // clear keeps the line count
    add_row(item(FUNC_CLEAR, 8'h00, 8'h00), 1'b0, '0);
    // backspace with a line but an empty stream
    add_row(item(FUNC_SCAN, SC_BACKSPACE | SC_RELEASE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_SCAN, SC_BACKSPACE, 8'h00), 1'b0, '0);
    add_row(item(FUNC_READ, SC_NONE, 8'h00), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) push_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // random phases: free flow, sender gaps, receiver stalls, both
    random_base = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 36;
          stall_pct = 36;
        end
      endcase
      if (ph == 3) begin
        long_line();
        phase_end = items_sent + TAIL_ITEMS;
      end else begin
        phase_end = random_base + PHASE_ITEMS * (ph + 1);
      end
      while (items_sent < phase_end) random_burst();
      // sender holds off until the block has drained
      req.valid <= 1'b0;
      do @(posedge clk); while (pending_results.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("%0d fresh presses, %0d drops at the limits, %0d reads inside the stream",
             fresh_presses, drops_seen, stream_hits);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
